FILE: sv/lpsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsu_pkg
// Shared constants, register indexes and saturation helper for the site updater.
// ----------------------------------------------------------------------------
package lpsu_pkg;

	localparam int MAX_SITES = 1024;
	localparam int ADDR_W    = $clog2(MAX_SITES);
	localparam int LEN_W     = ADDR_W + 1;
	localparam int COEF_W    = 31;
	localparam int VAL_W     = 32;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_METR = 2'd1;
	localparam logic [1:0] ACT_HEAT = 2'd2;
	localparam logic [1:0] ACT_OVER = 2'd3;

	localparam logic [2:0] REG_INV_ETA   = 3'd0;
	localparam logic [2:0] REG_SELF_COEF = 3'd1;
	localparam logic [2:0] REG_MEAN_GAIN = 3'd2;
	localparam logic [2:0] REG_SIGMA     = 3'd3;
	localparam logic [2:0] REG_STEP_W    = 3'd4;
	localparam logic [2:0] REG_LAT_LEN   = 3'd5;

	// clamp a wide signed value to the 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
		logic signed [43:0] hi;
		logic signed [43:0] lo;
		hi = 44'sd2147483647;
		lo = -44'sd2147483648;
		if (v > hi) begin
			sat32 = 32'sh7FFFFFFF;
		end else if (v < lo) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

FILE: sv/lattice_path_site_updater_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_path_site_updater_unit
// Path-integral Monte Carlo site update over a periodic ring of Q8.24 values.
// ----------------------------------------------------------------------------
// One input word names a site and an action (tuser: load, Metropolis, heatbath,
// overrelax) and yields one output word with the site's new value and an
// accepted flag. The block works on one word at a time: it reads the site and
// its two ring neighbours one after another over the single read port of the
// path RAM, then runs every product through one shared 33 x 32 signed
// multiplier under a small sequencer. Metropolis makes five multiplier passes;
// a site at or beyond the ring length answers zero without touching the ring.
// The path RAM has no reset: load every site in use before updating it.
// Coefficients must be written through the APB port while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lattice_path_site_updater_unit (
	input  logic         clk,
	input  logic         arst_n,
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input words
	input  logic         s_tvalid,
	output logic         s_tready,
	// site[9:0], load_value[41:10], proposal_uniform[66:42],
	// neg_log_uniform[97:67], gaussian_draw[129:98], zero pad[135:130]
	input  logic [135:0] s_tdata,
	// action[1:0]
	input  logic [1:0]   s_tuser,
	// output words
	output logic         m_tvalid,
	input  logic         m_tready,
	// new_value[31:0]
	output logic [31:0]  m_tdata,
	// accepted[0]
	output logic [0:0]   m_tuser
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RY   = 4'd1;
	localparam logic [3:0] ST_RP   = 4'd2;
	localparam logic [3:0] ST_RN   = 4'd3;
	localparam logic [3:0] ST_SUM  = 4'd4;
	localparam logic [3:0] ST_M1   = 4'd5;
	localparam logic [3:0] ST_M2   = 4'd6;
	localparam logic [3:0] ST_M3   = 4'd7;
	localparam logic [3:0] ST_M4   = 4'd8;
	localparam logic [3:0] ST_M5   = 4'd9;
	localparam logic [3:0] ST_MEAN = 4'd10;
	localparam logic [3:0] ST_HB   = 4'd11;
	localparam logic [3:0] ST_OR   = 4'd12;
	localparam logic [3:0] ST_WB   = 4'd13;

	localparam int AW = lpsu_pkg::ADDR_W;
	localparam int LW = lpsu_pkg::LEN_W;
	localparam int CW = lpsu_pkg::COEF_W;

	// configuration registers
	logic [CW-1:0] inv_eta_q, self_coef_q, mean_gain_q, sigma_q, step_w_q;
	logic [LW-1:0] lat_len_q;

	logic [3:0] state_q;

	// latched word
	logic [1:0]         act_q;
	logic [AW-1:0]      site_q, prev_q, next_q;
	logic signed [31:0] load_q;
	logic signed [24:0] unif_q;
	logic [30:0]        nlu_q;
	logic signed [31:0] gauss_q;

	// working registers
	logic signed [31:0] y_q, p_q, t_q, nv_q;
	logic signed [32:0] s_q, d_q;
	logic signed [41:0] m_q;
	logic signed [40:0] mean_q;
	logic signed [50:0] hi_q;
	logic               acc_q, we_q, out_valid_q;

	// RAM
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;

	lpsu_ram #(.WIDTH(lpsu_pkg::VAL_W), .DEPTH(lpsu_pkg::MAX_SITES)) u_path_ram (
		.clk   (clk),
		.we    (state_q == ST_WB && we_q),
		.waddr (site_q),
		.wdata (nv_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// walk site, previous, next on the single read port
	always_comb begin
		unique case (state_q)
			ST_RY:   raddr = site_q;
			ST_RP:   raddr = prev_q;
			default: raddr = next_q;
		endcase
	end

	// APB: always ready, register i at byte address 4*i
	logic       cfg_wr;
	logic [2:0] cfg_idx;
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (cfg_idx)
			lpsu_pkg::REG_INV_ETA:   prdata = {1'b0, inv_eta_q};
			lpsu_pkg::REG_SELF_COEF: prdata = {1'b0, self_coef_q};
			lpsu_pkg::REG_MEAN_GAIN: prdata = {1'b0, mean_gain_q};
			lpsu_pkg::REG_SIGMA:     prdata = {1'b0, sigma_q};
			lpsu_pkg::REG_STEP_W:    prdata = {1'b0, step_w_q};
			lpsu_pkg::REG_LAT_LEN:   prdata = {21'd0, lat_len_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// ring length clamped to [2, MAX_SITES]; neighbours wrap
	logic [LW-1:0] len_c, in_site_ext, len_m1;
	logic [AW-1:0] in_site;
	logic          in_range;
	always_comb begin
		if (lat_len_q < LW'(2)) begin
			len_c = LW'(2);
		end else if (lat_len_q > LW'(lpsu_pkg::MAX_SITES)) begin
			len_c = LW'(lpsu_pkg::MAX_SITES);
		end else begin
			len_c = lat_len_q;
		end
		in_site     = s_tdata[AW-1:0];
		in_site_ext = {1'b0, in_site};
		len_m1      = len_c - LW'(1);
		in_range    = in_site_ext < len_c;
	end

	// shared multiplier: operand select by step
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [64:0] prod;
	logic signed [40:0] prod_sh;
	always_comb begin
		unique case (state_q)
			ST_M1: begin
				mul_a = {2'b00, step_w_q};
				mul_b = {{7{unif_q[24]}}, unif_q};
			end
			ST_M2: begin
				mul_a = {t_q[31], t_q} + {y_q[31], y_q};
				mul_b = {1'b0, self_coef_q};
			end
			ST_M3: begin
				mul_a = s_q;
				mul_b = {1'b0, inv_eta_q};
			end
			ST_M4: begin
				mul_a = d_q;
				mul_b = {{14{m_q[41]}}, m_q[41:24]};
			end
			ST_M5: begin
				mul_a = d_q;
				mul_b = {8'd0, m_q[23:0]};
			end
			ST_MEAN: begin
				mul_a = s_q;
				mul_b = {1'b0, mean_gain_q};
			end
			ST_HB: begin
				mul_a = {gauss_q[31], gauss_q};
				mul_b = {1'b0, sigma_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod    = mul_a * mul_b;
		prod_sh = prod[64:24];
	end

	// Metropolis decision: dS = d*mh + floor(d*ml / 2^24)
	logic signed [52:0] ds;
	logic               metr_acc;
	always_comb begin
		ds       = {{2{hi_q[50]}}, hi_q} + {{12{prod_sh[40]}}, prod_sh};
		metr_acc = (ds <= 53'sd0) || (ds < $signed({22'd0, nlu_q}));
	end

	assign s_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = nv_q;
	assign m_tuser  = acc_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			inv_eta_q   <= 31'd16777216;
			self_coef_q <= 31'd25165824;
			mean_gain_q <= 31'd5592405;
			sigma_q     <= 31'd9686330;
			step_w_q    <= 31'd16777216;
			lat_len_q   <= LW'(lpsu_pkg::MAX_SITES);
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					lpsu_pkg::REG_INV_ETA:   inv_eta_q   <= pwdata[30:0];
					lpsu_pkg::REG_SELF_COEF: self_coef_q <= pwdata[30:0];
					lpsu_pkg::REG_MEAN_GAIN: mean_gain_q <= pwdata[30:0];
					lpsu_pkg::REG_SIGMA:     sigma_q     <= pwdata[30:0];
					lpsu_pkg::REG_STEP_W:    step_w_q    <= pwdata[30:0];
					lpsu_pkg::REG_LAT_LEN:   lat_len_q   <= pwdata[LW-1:0];
					default: ;
				endcase
			end
			// drop the result once taken
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						state_q <= in_range ? ST_RY : ST_WB;
					end
				end
				ST_RY:   state_q <= ST_RP;
				ST_RP:   state_q <= ST_RN;
				ST_RN:   state_q <= ST_SUM;
				ST_SUM: begin
					unique case (act_q)
						lpsu_pkg::ACT_LOAD: state_q <= ST_WB;
						lpsu_pkg::ACT_METR: state_q <= ST_M1;
						default:            state_q <= ST_MEAN;
					endcase
				end
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_M4;
				ST_M4:   state_q <= ST_M5;
				ST_M5:   state_q <= ST_WB;
				ST_MEAN: state_q <= (act_q == lpsu_pkg::ACT_HEAT) ? ST_HB : ST_OR;
				ST_HB:   state_q <= ST_WB;
				ST_OR:   state_q <= ST_WB;
				ST_WB: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tready) begin
					act_q   <= s_tuser;
					site_q  <= in_site;
					load_q  <= s_tdata[41:10];
					unif_q  <= s_tdata[66:42];
					nlu_q   <= s_tdata[97:67];
					gauss_q <= s_tdata[129:98];
					prev_q  <= (in_site == '0) ? len_m1[AW-1:0] : in_site - AW'(1);
					next_q  <= (in_site_ext == len_m1) ? '0 : in_site + AW'(1);
					// out-of-range site: answer zero, leave the ring alone
					nv_q    <= '0;
					acc_q   <= 1'b0;
					we_q    <= 1'b0;
				end
			end
			ST_RP: y_q <= rdata;
			ST_RN: p_q <= rdata;
			ST_SUM: begin
				s_q   <= {p_q[31], p_q} + {rdata[31], rdata};
				nv_q  <= load_q;
				acc_q <= 1'b1;
				we_q  <= 1'b1;
			end
			ST_M1: t_q <= lpsu_pkg::sat32({{12{y_q[31]}}, y_q} + {{3{prod_sh[40]}}, prod_sh});
			ST_M2: m_q <= {prod_sh[40], prod_sh};
			ST_M3: begin
				m_q <= m_q - {prod_sh[40], prod_sh};
				d_q <= {t_q[31], t_q} - {y_q[31], y_q};
			end
			ST_M4: hi_q <= prod[50:0];
			ST_M5: begin
				nv_q  <= metr_acc ? t_q : y_q;
				acc_q <= metr_acc;
			end
			ST_MEAN: mean_q <= prod_sh;
			ST_HB: nv_q <= lpsu_pkg::sat32({{3{mean_q[40]}}, mean_q}
				+ {{3{prod_sh[40]}}, prod_sh});
			ST_OR: nv_q <= lpsu_pkg::sat32({{2{mean_q[40]}}, mean_q, 1'b0}
				- {{12{y_q[31]}}, y_q});
			default: ;
		endcase
	end

endmodule

FILE: sv/lpsu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/lpsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsu_checker
// Port-level checks on the site updater, bound to the top level.
// ----------------------------------------------------------------------------
module lpsu_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [31:0]  m_tdata,
	input logic [0:0]   m_tuser
);

	// a waiting result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a word is taken only with the output register empty
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !m_tvalid)
		else $error("word accepted over a pending result");

	// busy after a word is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after accept");

	// one result per word: no refill straight after a take
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("second result without a word");

endmodule

bind lattice_path_site_updater_unit lpsu_checker u_lpsu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
